// ===== rtl/scfd_pkg.sv =====
// Shared constants and types for the sum-checked frame deframer.
// No dependencies; imported by the store, the parser, the emitter and the top level.
package scfd_pkg;

    localparam logic [7:0] HDR0           = 8'hAA;
    localparam logic [7:0] HDR1           = 8'h55;
    localparam int         BYTES_PER_WORD = 4;
    localparam int         IDX_OUT_W      = 4;
    localparam int         WORD_W         = 32;
    localparam int         FNUM_W         = 16;

    // Handoff from the parser to the emitter when a frame passes its checksum.
    typedef struct packed {
        logic              start;
        logic [FNUM_W-1:0] frame_number;
    } t_frame_done;

endpackage

// ===== rtl/scfd_store.sv =====
// Payload store: one 32-bit word per channel, written one byte lane at a time.
// Registered read port. No reset; every entry is written before use.
module scfd_store #(
    parameter int DEPTH  = 6,
    parameter int ADDR_W = 3
) (
    input  logic                             i_clk,
    input  logic                             i_wr_en,
    input  logic [ADDR_W-1:0]                i_wr_addr,
    input  logic [1:0]                       i_wr_lane,
    input  logic [7:0]                       i_wr_data,
    input  logic                             i_rd_en,
    input  logic [ADDR_W-1:0]                i_rd_addr,
    output logic [scfd_pkg::WORD_W-1:0]      o_rd_data
);
    import scfd_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr][{i_wr_lane, 3'b000} +: 8] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/scfd_parser.sv =====
// Header hunt, frame number capture, payload write and checksum compare.
// Uses scfd_pkg; drives the payload store and signals the emitter.
module scfd_parser #(
    parameter int CHANNELS = 6,
    parameter int IDX_W    = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_busy,
    output logic                  o_ready,
    output logic                  o_wr_en,
    output logic [IDX_W-1:0]      o_wr_addr,
    output logic [1:0]            o_wr_lane,
    output logic [7:0]            o_wr_data,
    output scfd_pkg::t_frame_done o_done
);
    import scfd_pkg::*;

    typedef enum logic [2:0] {
        S_HUNT0, S_HUNT1, S_LEN_HI, S_LEN_LO, S_NUM_HI, S_NUM_LO, S_DATA, S_SUM
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [IDX_W-1:0]  r_word;
    logic [1:0]        r_lane;
    logic [7:0]        r_sum;
    logic [FNUM_W-1:0] r_fnum;
    logic              r_start;
    logic              take;
    logic              last_byte;

    assign o_ready   = !i_busy;
    assign take      = i_valid && !i_busy;
    assign last_byte = (r_word == IDX_W'(CHANNELS - 1)) && (r_lane == 2'd3);

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            S_HUNT0:  if (i_data_byte == HDR0) n_phase = S_HUNT1;
            S_HUNT1: begin
                if (i_data_byte == HDR1)      n_phase = S_LEN_HI;
                else if (i_data_byte == HDR0) n_phase = S_HUNT1;
                else                          n_phase = S_HUNT0;
            end
            S_LEN_HI: n_phase = S_LEN_LO;
            S_LEN_LO: n_phase = S_NUM_HI;
            S_NUM_HI: n_phase = S_NUM_LO;
            S_NUM_LO: n_phase = S_DATA;
            S_DATA:   if (last_byte) n_phase = S_SUM;
            S_SUM:    n_phase = S_HUNT0;
            default:  n_phase = S_HUNT0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= S_HUNT0;
            r_word  <= '0;
            r_lane  <= '0;
            r_sum   <= '0;
            r_fnum  <= '0;
            r_start <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (take) begin
                r_phase <= n_phase;
                unique case (r_phase)
                    S_NUM_HI: r_fnum[15:8] <= i_data_byte;
                    S_NUM_LO: begin
                        r_fnum[7:0] <= i_data_byte;
                        r_word      <= '0;
                        r_lane      <= '0;
                        r_sum       <= '0;
                    end
                    S_DATA: begin
                        r_sum  <= r_sum + i_data_byte;
                        r_lane <= r_lane + 2'd1;
                        if (r_lane == 2'd3) r_word <= r_word + IDX_W'(1);
                    end
                    S_SUM: begin
                        r_start <= (i_data_byte == r_sum);
                        r_word  <= '0;
                        r_lane  <= '0;
                        r_sum   <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_wr_en   = take && (r_phase == S_DATA);
    assign o_wr_addr = r_word;
    assign o_wr_lane = r_lane;
    assign o_wr_data = i_data_byte;

    // start is registered: the store write of the last data byte has long settled
    assign o_done.start        = r_start;
    assign o_done.frame_number = r_fnum;

endmodule

// ===== rtl/scfd_emitter.sv =====
// Reads one channel word per request from the payload store and presents it
// on the output register. Uses scfd_pkg; driven by the parser's frame handoff.
module scfd_emitter #(
    parameter int CHANNELS = 6,
    parameter int IDX_W    = 3
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  scfd_pkg::t_frame_done               i_done,
    output logic                                o_busy,
    output logic                                o_rd_en,
    output logic [IDX_W-1:0]                    o_rd_addr,
    input  logic [scfd_pkg::WORD_W-1:0]         i_rd_data,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [scfd_pkg::IDX_OUT_W-1:0]      o_channel_index,
    output logic [scfd_pkg::WORD_W-1:0]         o_channel_word,
    output logic [scfd_pkg::FNUM_W-1:0]         o_frame_number,
    output logic                                o_last
);
    import scfd_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_READ, S_LOAD, S_HOLD} t_state;

    t_state            r_state;
    logic [IDX_W-1:0]  r_idx;
    logic              r_valid;
    logic [WORD_W-1:0] r_word;
    logic [FNUM_W-1:0] r_fnum;
    logic              is_last;
    logic              advance;

    assign is_last = (r_idx == IDX_W'(CHANNELS - 1));
    assign advance = (r_state == S_HOLD) && i_ready && !is_last;

    // busy covers the cycle the handoff arrives so no new byte is taken then
    assign o_busy    = (r_state != S_IDLE) || i_done.start;
    assign o_rd_en   = (r_state == S_READ) || advance;
    assign o_rd_addr = (r_state == S_READ) ? r_idx : r_idx + IDX_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_done.start) begin
                        r_fnum  <= i_done.frame_number;
                        r_idx   <= '0;
                        r_state <= S_READ;
                    end
                end
                S_READ: r_state <= S_LOAD;
                S_LOAD: begin
                    r_word  <= i_rd_data;
                    r_valid <= 1'b1;
                    r_state <= S_HOLD;
                end
                S_HOLD: begin
                    if (i_ready) begin
                        r_valid <= 1'b0;
                        if (is_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + IDX_W'(1);
                            r_state <= S_LOAD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid         = r_valid;
    assign o_channel_index = IDX_OUT_W'(r_idx);
    assign o_channel_word  = r_word;
    assign o_frame_number  = r_fnum;
    assign o_last          = is_last;

    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_done.start |-> (r_state == S_IDLE))
        else $error("frame handoff while emitter busy");

    a_valid_only_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_state == S_HOLD))
        else $error("output valid outside hold state");

    a_last_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HOLD && i_ready && is_last) |=> (r_state == S_IDLE) && !r_valid)
        else $error("emitter did not return to idle after last channel");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_idx <= IDX_W'(CHANNELS - 1)))
        else $error("channel index past last channel");

endmodule

// ===== rtl/sum_checked_frame_deframer_core.sv =====
// Top level of the sum-checked frame deframer.
// Uses scfd_pkg, scfd_store, scfd_parser and scfd_emitter.
//
// Input channel (i_valid / o_ready / i_data_byte): one stream byte per request.
// The parser hunts for 0xAA 0x55, skips two length bytes, captures a two-byte
// frame number (high byte first), writes CHANNELS*4 data bytes into the
// payload store and keeps their 8-bit sum. While a frame is being parsed, a
// byte is taken every cycle that i_valid is high; a frame is 7 + 4*CHANNELS
// bytes long.
// Output channel (o_valid / i_ready / result fields): when the checksum byte
// matches, CHANNELS requests follow, channel 0 first, o_last on the final one.
// The match is registered, then the emitter reads and loads the first word;
// each later word costs one store read and a load before it is shown.
// A failed checksum drops the frame with no result and does not hold off input.
// While results are pending o_ready is low; the input resumes the cycle after
// the last result is taken. A stalled receiver simply holds the current result
// in the output register, which freezes the emitter and the input side.
// Reset (i_rst_n low, synchronous) returns to header hunting and drops any
// pending results; the payload store is not cleared, as every entry is
// rewritten before it is read.
module sum_checked_frame_deframer_core #(
    parameter int CHANNELS = 6
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [7:0]                          i_data_byte,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [scfd_pkg::IDX_OUT_W-1:0]      o_channel_index,
    output logic [scfd_pkg::WORD_W-1:0]         o_channel_word,
    output logic [scfd_pkg::FNUM_W-1:0]         o_frame_number,
    output logic                                o_last
);
    import scfd_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    t_frame_done       done;
    logic              busy;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [1:0]        wr_lane;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [WORD_W-1:0] rd_data;

    scfd_parser #(
        .CHANNELS (CHANNELS),
        .IDX_W    (IDX_W)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data_byte (i_data_byte),
        .i_busy      (busy),
        .o_ready     (o_ready),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_lane   (wr_lane),
        .o_wr_data   (wr_data),
        .o_done      (done)
    );

    scfd_store #(
        .DEPTH  (CHANNELS),
        .ADDR_W (IDX_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_lane (wr_lane),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    scfd_emitter #(
        .CHANNELS (CHANNELS),
        .IDX_W    (IDX_W)
    ) u_emitter (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_done          (done),
        .o_busy          (busy),
        .o_rd_en         (rd_en),
        .o_rd_addr       (rd_addr),
        .i_rd_data       (rd_data),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_channel_index (o_channel_index),
        .o_channel_word  (o_channel_word),
        .o_frame_number  (o_frame_number),
        .o_last          (o_last)
    );

endmodule
